FILE: rtl/core/rtm_pkg.sv
`timescale 1ns / 1ps
// rtm_pkg: shared types, constants and helpers for the raw temperature converter
// no dependencies; imported by raw_temperature_to_millidegrees_top

package rtm_pkg;

    // raw reading port and significant width of the sensor value
    localparam int RAW_W    = 32;
    localparam int RAW_BITS = 32;
    localparam int RAW_PAD  = RAW_W - RAW_BITS;

    // apb register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int ENC_W  = 3;
    localparam int FAIL_W = 31;

    typedef enum logic [ENC_W-1:0] {
        ENC_PASS      = 3'd0,
        ENC_LIN11     = 3'd1,
        ENC_DIODE     = 3'd2,
        ENC_DIE_LIN   = 3'd3,
        ENC_DIE_RECIP = 3'd4
    } encoding_t;

    typedef enum logic {
        REG_ENCODING  = 1'b0,
        REG_FAIL_CODE = 1'b1
    } reg_index_t;

    // result widths
    localparam int TEMP_W = 28;
    localparam int VAL_W  = 37;

    // linear11
    localparam int MANT_W      = 11;
    localparam int EXPO_W      = 5;
    localparam int LIN11_SCALE = 1000;
    localparam int LIN_W       = 21;
    localparam int LIN_SH_W    = 36;

    // sign-magnitude diode: x*625/80 == x*125/16
    localparam int DIODE_MAG_W = 14;
    localparam int DIODE_NEG_W = 11;
    localparam int DIODE_NUM   = 125;
    localparam int DIODE_SHIFT = 4;
    localparam int DIODE_P_W   = 21;
    localparam int DIODE_R_W   = DIODE_P_W - DIODE_SHIFT + 1;

    // linear die: (u*317704)/2000 == floor(floor(u*39713/2)/125)
    localparam int DLIN_T_SHIFT = 4;
    localparam int DLIN_T_W     = RAW_W - DLIN_T_SHIFT;
    localparam int DLIN_U_FULL  = DLIN_T_W + 1;
    localparam int DLIN_OFS     = 2;
    localparam int DLIN_U_W     = 12;
    localparam int DLIN_NUM     = 39713;
    localparam int DLIN_X_W     = 28;
    localparam int DLIN_W_W     = DLIN_X_W - 1;
    localparam int DLIN_RECIP   = 137438954;
    localparam int DLIN_RECIP_SH = 34;
    localparam int DLIN_P_W     = 55;
    localparam int DLIN_Q_W     = DLIN_P_W - DLIN_RECIP_SH;
    localparam int DLIN_BASE    = 476359;

    // reciprocal die: only readings 128..383 can land inside the -70..200 window
    localparam int REC_LO     = 128;
    localparam int REC_HI     = 383;
    localparam int REC_DATA_W = 9;
    localparam int REC_SCALE  = 100;
    localparam int REC_D_W    = 16;
    localparam logic [23:0] DIV_NUM = 24'd12500000;
    localparam int DIV_Q_W    = 10;
    localparam int DIV_STEPS1 = 5;
    localparam logic [REC_D_W-1:0] DIV_R_INIT = REC_D_W'(DIV_NUM >> DIV_Q_W);
    localparam int REC_Q_LO   = 436;
    localparam int REC_Q_HI   = 944;
    localparam int REC_MUL    = 535;
    localparam int REC_P_W    = 20;
    localparam int REC_BASE   = 434100;

    // final window
    localparam logic signed [VAL_W-1:0]  LOW_LIMIT    = VAL_W'(-40000);
    localparam logic signed [VAL_W-1:0]  HIGH_LIMIT   = VAL_W'(120000);
    localparam logic signed [TEMP_W-1:0] TEMP_LOW     = TEMP_W'(-40000);
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH    = TEMP_W'(120000);
    localparam logic signed [TEMP_W-1:0] INVALID_TEMP = TEMP_W'(-99999999);

    // pipeline stage contents
    typedef struct packed {
        logic [ENC_W-1:0]         enc;
        logic signed [RAW_W-1:0]  data;
        logic signed [MANT_W-1:0] mant;
        logic signed [EXPO_W-1:0] expo;
        logic [DIODE_MAG_W-1:0]   dmag;
        logic                     dneg;
        logic                     dbig;
        logic [DLIN_U_W-1:0]      du;
        logic                     dfit;
        logic [REC_D_W-1:0]       rden;
        logic                     rfit;
    } s1_t;

    typedef struct packed {
        logic [ENC_W-1:0]         enc;
        logic signed [RAW_W-1:0]  data;
        logic signed [LIN_W-1:0]  lin_val;
        logic signed [EXPO_W-1:0] expo;
        logic [DIODE_P_W-1:0]     dprod;
        logic                     dneg;
        logic                     dbig;
        logic [DLIN_X_W-1:0]      dx;
        logic                     dfit;
        logic [REC_D_W-1:0]       rrem;
        logic [REC_D_W-1:0]       rden;
        logic [DIV_Q_W-1:0]       rquo;
        logic                     rfit;
    } s2_t;

    typedef struct packed {
        logic [ENC_W-1:0]            enc;
        logic signed [RAW_W-1:0]     data;
        logic signed [LIN_SH_W-1:0]  lin_res;
        logic signed [DIODE_R_W-1:0] diode_res;
        logic                        dbig;
        logic [DLIN_P_W-1:0]         dprod;
        logic                        dfit;
        logic [DIV_Q_W-1:0]          rquo;
        logic                        rfit;
    } s3_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    force_out;
    } s4_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [REC_D_W:0] div_step(
        input logic [REC_D_W-1:0] rem,
        input logic [REC_D_W-1:0] den,
        input logic               nbit
    );
        logic [REC_D_W:0] trial;
        logic [REC_D_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
        begin
            return {1'b1, diff[REC_D_W-1:0]};
        end
        return {1'b0, trial[REC_D_W-1:0]};
    endfunction

endpackage

FILE: rtl/core/raw_temperature_to_millidegrees_top.sv
`timescale 1ns / 1ps
// raw_temperature_to_millidegrees_top: converts raw sensor readings to millidegrees
// depends on rtm_pkg

// A five-stage pipeline that takes one raw reading per clock while the result side does
// not stall, and returns one result per reading, in order. A taken request passes
// through stage 1, stage 2, stage 3, stage 4 and the output register before it reaches
// the result channel. The pipeline depth is set by the ten-step restoring divider of the
// reciprocal die formula, which is split over two stages. It is also set by the reciprocal
// multiply of the linear die formula, which shares the third stage with the second half
// of the divider. Each stage holds its contents while the stage after it is full and
// stalled, so input is still taken while bubbles remain in the pipeline. The encoding
// and fail code registers are read by the stages directly and must only be written while
// no request is in flight. Results outside -40000..120000 millidegrees are reported as
// -99999999 with in_range low.

module raw_temperature_to_millidegrees_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // reading channel
    input  logic                              reading_valid,
    output logic                              reading_ready,
    input  logic signed [rtm_pkg::RAW_W-1:0]  raw_reading,
    // result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [rtm_pkg::TEMP_W-1:0] temperature_milli,
    output logic                              in_range,
    // apb register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtm_pkg::ADDR_W-1:0]        paddr,
    input  logic [rtm_pkg::DATA_W-1:0]        pwdata,
    output logic [rtm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import rtm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ENC_W-1:0]  encoding_reg;
    logic [ENC_W-1:0]  encoding_next;
    logic [FAIL_W-1:0] fail_code_reg;
    logic [FAIL_W-1:0] fail_code_next;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // only the word address bit selects a register, byte offsets are ignored
    always_comb
    begin
        encoding_next  = encoding_reg;
        fail_code_next = fail_code_reg;
        if (cfg_wr)
        begin
            case (reg_index_t'(paddr[2]))
                REG_ENCODING:  encoding_next  = pwdata[ENC_W-1:0];
                REG_FAIL_CODE: fail_code_next = pwdata[FAIL_W-1:0];
                default:       encoding_next  = encoding_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_ENCODING:  prdata = DATA_W'(encoding_reg);
            REG_FAIL_CODE: prdata = DATA_W'(fail_code_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg  <= ENC_PASS;
            fail_code_reg <= FAIL_W'(1);
        end
        else
        begin
            encoding_reg  <= encoding_next;
            fail_code_reg <= fail_code_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or draining
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, out_valid_next;
    logic en1, en2, en3, en4, en5;

    assign en5 = !out_valid_reg | result_ready;
    assign en4 = !v4_reg | en5;
    assign en3 = !v3_reg | en4;
    assign en2 = !v2_reg | en3;
    assign en1 = !v1_reg | en2;

    assign reading_ready = en1;
    assign result_valid  = out_valid_reg;

    assign v1_next        = en1 ? reading_valid : v1_reg;
    assign v2_next        = en2 ? v1_reg : v2_reg;
    assign v3_next        = en3 ? v2_reg : v3_reg;
    assign v4_next        = en4 ? v3_reg : v4_reg;
    assign out_valid_next = en5 ? v4_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: field extraction and range pre-checks
    // ------------------------------------------------------------------
    s1_t s1_reg, s1_next;

    logic signed [RAW_W-1:0]       data_s;
    logic signed [DLIN_T_W-1:0]    dlin_t;
    logic signed [DLIN_U_FULL-1:0] dlin_u;

    always_comb
    begin
        // sign-extend from the significant width of the sensor
        data_s = (raw_reading <<< RAW_PAD) >>> RAW_PAD;

        s1_next.enc  = encoding_reg;
        s1_next.data = data_s;

        // linear11 fields from the low half word
        s1_next.expo = data_s[MANT_W+EXPO_W-1:MANT_W];
        s1_next.mant = data_s[MANT_W-1:0];

        // diode: positive readings above the magnitude width are always out of window
        s1_next.dneg = data_s[RAW_W-1];
        s1_next.dmag = s1_next.dneg ? DIODE_MAG_W'(data_s[DIODE_NEG_W-1:0])
                                    : data_s[DIODE_MAG_W-1:0];
        s1_next.dbig = !s1_next.dneg && (|data_s[RAW_W-2:DIODE_MAG_W]);

        // linear die: offset reading outside 0..4095 cannot reach the window
        dlin_t       = $signed(data_s[RAW_W-1:DLIN_T_SHIFT]);
        dlin_u       = DLIN_U_FULL'(dlin_t) - DLIN_U_FULL'(DLIN_OFS);
        s1_next.du   = dlin_u[DLIN_U_W-1:0];
        s1_next.dfit = (dlin_u[DLIN_U_FULL-1:DLIN_U_W] == '0);

        // reciprocal die: divisor reading*100-1 for the only useful readings
        s1_next.rfit = (data_s >= REC_LO) && (data_s <= REC_HI);
        s1_next.rden = REC_D_W'(data_s[REC_DATA_W-1:0]) * REC_D_W'(REC_SCALE)
                       - REC_D_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: constant multiplies, first half of the divider
    // ------------------------------------------------------------------
    s2_t s2_reg, s2_next;

    logic signed [LIN_W-1:0] mant_ext;
    logic signed [LIN_W-1:0] lin_scale;
    logic [REC_D_W:0]        step2;
    logic [REC_D_W-1:0]      rem2;
    logic [DIV_Q_W-1:0]      quo2;

    always_comb
    begin
        s2_next.enc  = s1_reg.enc;
        s2_next.data = s1_reg.data;
        s2_next.expo = s1_reg.expo;

        mant_ext        = LIN_W'(s1_reg.mant);
        lin_scale       = LIN_W'(LIN11_SCALE);
        s2_next.lin_val = mant_ext * lin_scale;

        s2_next.dprod = DIODE_P_W'(s1_reg.dmag) * DIODE_P_W'(DIODE_NUM);
        s2_next.dneg  = s1_reg.dneg;
        s2_next.dbig  = s1_reg.dbig;

        s2_next.dx   = DLIN_X_W'(s1_reg.du) * DLIN_X_W'(DLIN_NUM);
        s2_next.dfit = s1_reg.dfit;

        // quotient bits 9..5
        rem2 = DIV_R_INIT;
        quo2 = '0;
        for (int i = 0; i < DIV_STEPS1; i++)
        begin
            step2 = div_step(rem2, s1_reg.rden, DIV_NUM[DIV_Q_W-1-i]);
            rem2  = step2[REC_D_W-1:0];
            quo2[DIV_Q_W-1-i] = step2[REC_D_W];
        end
        s2_next.rrem = rem2;
        s2_next.rquo = quo2;
        s2_next.rden = s1_reg.rden;
        s2_next.rfit = s1_reg.rfit;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: linear11 shift, diode scale, reciprocal multiply, divider end
    // ------------------------------------------------------------------
    s3_t s3_reg, s3_next;

    logic signed [LIN_SH_W-1:0]      lin_ext;
    logic [EXPO_W-1:0]               neg_amt;
    logic [DIODE_R_W-2:0]            diode_q;
    logic [DLIN_W_W-1:0]             dlin_w;
    logic [REC_D_W:0]                step3;
    logic [REC_D_W-1:0]              rem3;
    logic [DIV_Q_W-1:0]              quo3;

    always_comb
    begin
        s3_next.enc  = s2_reg.enc;
        s3_next.data = s2_reg.data;

        // negative exponent shifts right with floor rounding
        lin_ext = LIN_SH_W'(s2_reg.lin_val);
        neg_amt = EXPO_W'(-s2_reg.expo);
        if (s2_reg.expo[EXPO_W-1])
        begin
            s3_next.lin_res = lin_ext >>> neg_amt;
        end
        else
        begin
            s3_next.lin_res = lin_ext <<< s2_reg.expo[EXPO_W-2:0];
        end

        diode_q = s2_reg.dprod[DIODE_P_W-1:DIODE_SHIFT];
        s3_next.diode_res = s2_reg.dneg ? -$signed({1'b0, diode_q})
                                        :  $signed({1'b0, diode_q});
        s3_next.dbig = s2_reg.dbig;

        // divide by 250 as halve then multiply by the reciprocal of 125
        dlin_w        = s2_reg.dx[DLIN_X_W-1:1];
        s3_next.dprod = DLIN_P_W'(dlin_w) * DLIN_P_W'(DLIN_RECIP);
        s3_next.dfit  = s2_reg.dfit;

        // quotient bits 4..0
        rem3 = s2_reg.rrem;
        quo3 = s2_reg.rquo;
        for (int i = DIV_STEPS1; i < DIV_Q_W; i++)
        begin
            step3 = div_step(rem3, s2_reg.rden, DIV_NUM[DIV_Q_W-1-i]);
            rem3  = step3[REC_D_W-1:0];
            quo3[DIV_Q_W-1-i] = step3[REC_D_W];
        end
        s3_next.rquo = quo3;
        s3_next.rfit = s2_reg.rfit;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: formula tails and selection by encoding
    // ------------------------------------------------------------------
    s4_t s4_reg, s4_next;

    logic [DLIN_Q_W-1:0]     dlin_q;
    logic [REC_P_W-1:0]      rec_prod;
    logic signed [VAL_W-1:0] rec_val;
    logic signed [VAL_W-1:0] fail_val;
    logic                    rec_ok;

    always_comb
    begin
        dlin_q   = s3_reg.dprod[DLIN_P_W-1:DLIN_RECIP_SH];
        rec_prod = REC_P_W'(s3_reg.rquo) * REC_P_W'(REC_MUL);
        rec_val  = $signed(VAL_W'(REC_BASE)) - $signed(VAL_W'(rec_prod));
        fail_val = -$signed(VAL_W'(fail_code_reg));
        // quotient 436..944 is exactly the -70..200 degree window
        rec_ok   = s3_reg.rfit && (s3_reg.rquo >= DIV_Q_W'(REC_Q_LO))
                   && (s3_reg.rquo <= DIV_Q_W'(REC_Q_HI));

        s4_next.force_out = 1'b0;
        case (s3_reg.enc)
            ENC_LIN11:
            begin
                s4_next.val = VAL_W'(s3_reg.lin_res);
            end
            ENC_DIODE:
            begin
                s4_next.val       = VAL_W'(s3_reg.diode_res);
                s4_next.force_out = s3_reg.dbig;
            end
            ENC_DIE_LIN:
            begin
                s4_next.val       = $signed(VAL_W'(DLIN_BASE)) - $signed(VAL_W'(dlin_q));
                s4_next.force_out = !s3_reg.dfit;
            end
            ENC_DIE_RECIP:
            begin
                s4_next.val = rec_ok ? rec_val : fail_val;
            end
            default:
            begin
                s4_next.val = VAL_W'(s3_reg.data);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: window check into the output register
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] milli_out_reg, milli_out_next;
    logic                     in_range_reg, in_range_next;

    always_comb
    begin
        in_range_next  = !s4_reg.force_out && (s4_reg.val >= LOW_LIMIT)
                         && (s4_reg.val <= HIGH_LIMIT);
        milli_out_next = in_range_next ? s4_reg.val[TEMP_W-1:0] : INVALID_TEMP;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            milli_out_reg <= milli_out_next;
            in_range_reg  <= in_range_next;
        end
    end

    assign temperature_milli = milli_out_reg;
    assign in_range          = in_range_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && in_range |->
            (temperature_milli >= TEMP_LOW) && (temperature_milli <= TEMP_HIGH))
        else $error("in-range result outside window");

    a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_range |-> temperature_milli == INVALID_TEMP)
        else $error("out-of-range result without invalid marker");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> reading_ready)
        else $error("empty first stage refused a request");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        reading_valid && reading_ready |=> v1_reg)
        else $error("accepted request lost at first stage");

    a_enc_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == REG_ENCODING) |=>
            encoding_reg == $past(pwdata[ENC_W-1:0]))
        else $error("encoding write not taken");

endmodule
